// ----- hw/rtl/cc20_pkg.sv -----
// Shared types, constants and helpers for the ChaCha20 keystream XOR block.
package cc20_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] block_t;

  localparam word_t SIGMA_0 = 32'h6170_7865;
  localparam word_t SIGMA_1 = 32'h3320_646e;
  localparam word_t SIGMA_2 = 32'h7962_2d32;
  localparam word_t SIGMA_3 = 32'h6b20_6574;

  localparam int ROUNDS      = 20;
  // one ARX step per cycle: 4 steps per quarter round, 4 quarter rounds per round
  localparam int ROUND_STEPS = ROUNDS * 16;
  localparam int STEP_CNT_W  = $clog2(ROUND_STEPS);

  localparam int BLOCK_BYTES = 64;
  localparam int POS_W       = $clog2(BLOCK_BYTES) + 1;

  // op field codes
  localparam logic OP_DATA    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE = 3'd4;

  // rotate of the ARX step selected by the sub-step number
  function automatic word_t arx_rotl(input word_t x, input logic [1:0] sub);
    word_t r;
    case (sub)
      2'd0:    r = {x[15:0], x[31:16]};
      2'd1:    r = {x[19:0], x[31:20]};
      2'd2:    r = {x[23:0], x[31:24]};
      2'd3:    r = {x[24:0], x[31:25]};
      default: r = x;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/cc20_if.sv -----
// Valid/ready channel interfaces for input words and result words.
interface cc20_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;
  logic       starts_call;

  modport source (output valid, output op, output data_byte, output starts_call,
                  input ready);
  modport sink   (input valid, input op, input data_byte, input starts_call,
                  output ready);
endinterface

interface cc20_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface

// ----- hw/rtl/cc20_core.sv -----
// ChaCha20 block function on one shared 32-bit add/xor/rotate unit.
module cc20_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  cc20_pkg::block_t  init_words,
  output cc20_pkg::block_t  ks_words,
  output logic              done
);

  typedef enum logic [2:0] {
    CS_IDLE  = 3'b001,
    CS_ROUND = 3'b010,
    CS_FINAL = 3'b100
  } core_state_t;

  core_state_t                          st_r, st_nxt;
  logic [cc20_pkg::STEP_CNT_W-1:0]      cnt_r, cnt_nxt;
  cc20_pkg::block_t                     w_r, w_nxt;

  logic [1:0]        sub;
  logic [1:0]        qr;
  logic              diag;
  logic              last_round;
  logic              last_final;
  cc20_pkg::word_t   opa, opb, sum, mix;
  cc20_pkg::block_t  arx_w;
  logic [3:0][1:0]   shamt;

  // rotate each row of four words left by its own amount
  function automatic cc20_pkg::block_t row_shift(input cc20_pkg::block_t b,
                                                 input logic [3:0][1:0] k);
    cc20_pkg::block_t o;
    logic [1:0]       col;
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 4; j++) begin
        col = 2'(j) + k[r];
        o[4*r+j] = b[{2'(r), col}];
      end
    end
    return o;
  endfunction

  assign sub        = cnt_r[1:0];
  assign qr         = cnt_r[3:2];
  assign diag       = cnt_r[4];
  assign last_round = (cnt_r == cc20_pkg::STEP_CNT_W'(cc20_pkg::ROUND_STEPS - 1));
  assign last_final = (cnt_r[3:0] == 4'hf);

  // column 0 of the rotated state always holds the current quarter round
  always_comb begin
    if (st_r == CS_FINAL) begin
      opa = w_r[0];
      opb = init_words[cnt_r[3:0]];
    end else if (sub[0]) begin
      opa = w_r[8];
      opb = w_r[12];
    end else begin
      opa = w_r[0];
      opb = w_r[4];
    end
  end

  assign sum = opa + opb;
  assign mix = cc20_pkg::arx_rotl((sub[0] ? w_r[4] : w_r[12]) ^ sum, sub);

  always_comb begin
    arx_w = w_r;
    if (sub[0]) begin
      arx_w[8] = sum;
      arx_w[4] = mix;
    end else begin
      arx_w[0] = sum;
      arx_w[12] = mix;
    end
  end

  // after a quarter round bring the next column to position 0; at the end of
  // a round also move between column and diagonal layout
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      if (qr != 2'd3) begin
        shamt[r] = 2'd1;
      end else if (diag) begin
        shamt[r] = 2'd1 - 2'(r);
      end else begin
        shamt[r] = 2'd1 + 2'(r);
      end
    end
  end

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    w_nxt   = w_r;
    case (st_r)
      CS_IDLE: begin
        if (start) begin
          w_nxt   = init_words;
          cnt_nxt = '0;
          st_nxt  = CS_ROUND;
        end
      end
      CS_ROUND: begin
        w_nxt   = (sub == 2'd3) ? row_shift(arx_w, shamt) : arx_w;
        cnt_nxt = last_round ? '0 : cnt_r + 1'b1;
        if (last_round) begin
          st_nxt = CS_FINAL;
        end
      end
      CS_FINAL: begin
        // feed-forward add while the state shifts through word 0
        w_nxt   = {sum, w_r[15:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (last_final) begin
          st_nxt = CS_IDLE;
        end
      end
      default: begin
        st_nxt = CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= CS_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
  end

  assign ks_words = w_r;
  assign done     = (st_r == CS_FINAL) && last_final;

endmodule

// ----- hw/rtl/chacha20_keystream_xor.sv -----
// ChaCha20 (20 rounds, 64-bit counter and nonce) keystream XOR, one byte per word.
// A data word whose keystream byte is already held has its result registered at
// the edge that takes it if the result slot is free, else it waits in ST_EMIT. A
// word that needs a new 64-byte block (start of a call, or the previous block used
// up) waits for the block function, which runs on a single 32-bit add/xor/rotate
// unit doing one quarter-round step per cycle: the rounds, then the feed-forward
// add; the word then passes from ST_BUSY to ST_EMIT, where its result is
// registered once the result slot is free. No new word is taken until then. A
// restart word clears the block counter and gives no result.
// Configuration must be written only while the block is idle.
module chacha20_keystream_xor (
  input  logic                            clk,
  input  logic                            rst_n,
  cc20_in_if.sink                         in_ch,
  cc20_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [cc20_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                     cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_BUSY = 3'b010,
    ST_EMIT = 3'b100
  } top_state_t;

  top_state_t                      st_r, st_nxt;
  logic [3:0][63:0]                key_r;
  logic [63:0]                     nonce_r;
  logic [63:0]                     blk_cnt_r, blk_cnt_nxt;
  logic [cc20_pkg::POS_W-1:0]      pos_r, pos_nxt;
  logic [7:0]                      data_r, data_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [7:0]                      out_byte_r, out_byte_nxt;

  cc20_pkg::block_t  init_words;
  cc20_pkg::block_t  ks_words;
  cc20_pkg::word_t   ks_word;
  logic [7:0]        ks_byte;
  logic              core_start;
  logic              core_done;
  logic              in_fire;
  logic              slot_free;
  logic              need_block;

  always_comb begin
    init_words[0]  = cc20_pkg::SIGMA_0;
    init_words[1]  = cc20_pkg::SIGMA_1;
    init_words[2]  = cc20_pkg::SIGMA_2;
    init_words[3]  = cc20_pkg::SIGMA_3;
    for (int k = 0; k < 4; k++) begin
      init_words[4+2*k] = key_r[k][31:0];
      init_words[5+2*k] = key_r[k][63:32];
    end
    init_words[12] = blk_cnt_r[31:0];
    init_words[13] = blk_cnt_r[63:32];
    init_words[14] = nonce_r[31:0];
    init_words[15] = nonce_r[63:32];
  end

  cc20_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (core_start),
    .init_words (init_words),
    .ks_words   (ks_words),
    .done       (core_done)
  );

  assign ks_word = ks_words[pos_r[cc20_pkg::POS_W-2:2]];
  assign ks_byte = 8'(ks_word >> {pos_r[1:0], 3'b000});

  assign in_ch.ready = (st_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign need_block  = in_ch.starts_call || pos_r[cc20_pkg::POS_W-1];

  always_comb begin
    st_nxt        = st_r;
    blk_cnt_nxt   = blk_cnt_r;
    pos_nxt       = pos_r;
    data_nxt      = data_r;
    out_byte_nxt  = out_byte_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    core_start    = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.op == cc20_pkg::OP_RESTART) begin
            blk_cnt_nxt = '0;
          end else begin
            data_nxt = in_ch.data_byte;
            if (need_block) begin
              core_start = 1'b1;
              pos_nxt    = '0;
              st_nxt     = ST_BUSY;
            end else if (slot_free) begin
              out_byte_nxt  = in_ch.data_byte ^ ks_byte;
              out_valid_nxt = 1'b1;
              pos_nxt       = pos_r + 1'b1;
            end else begin
              st_nxt = ST_EMIT;
            end
          end
        end
      end
      ST_BUSY: begin
        if (core_done) begin
          blk_cnt_nxt = blk_cnt_r + 64'd1;
          st_nxt      = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_byte_nxt  = data_r ^ ks_byte;
          out_valid_nxt = 1'b1;
          pos_nxt       = pos_r + 1'b1;
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      blk_cnt_r   <= '0;
      pos_r       <= cc20_pkg::POS_W'(cc20_pkg::BLOCK_BYTES);
      out_valid_r <= 1'b0;
      key_r       <= '0;
      nonce_r     <= '0;
    end else begin
      st_r        <= st_nxt;
      blk_cnt_r   <= blk_cnt_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          cc20_pkg::CFG_KEY_0: key_r[0] <= cfg_wdata;
          cc20_pkg::CFG_KEY_1: key_r[1] <= cfg_wdata;
          cc20_pkg::CFG_KEY_2: key_r[2] <= cfg_wdata;
          cc20_pkg::CFG_KEY_3: key_r[3] <= cfg_wdata;
          cc20_pkg::CFG_NONCE: nonce_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r     <= data_nxt;
    out_byte_r <= out_byte_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;

endmodule

// ----- hw/rtl/cc20_checker.sv -----
// Port-level checks for the ChaCha20 keystream XOR block, bound to the top level.
module cc20_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_op,
  input logic       in_starts_call,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte
);

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("result word changed or dropped while stalled");

  // a restart gives no result word
  a_restart_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_op == cc20_pkg::OP_RESTART) && !out_valid |=> !out_valid)
    else $error("restart produced a result word");

  // a call start always runs the block function
  a_call_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_op == cc20_pkg::OP_DATA) && in_starts_call |=> !in_ready)
    else $error("call start did not generate a new block");

  // no result can come out right after a call start
  a_call_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_op == cc20_pkg::OP_DATA) && in_starts_call && !out_valid
      |=> !out_valid)
    else $error("result word ahead of block generation");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind chacha20_keystream_xor cc20_checker u_cc20_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_op          (in_ch.op),
  .in_starts_call (in_ch.starts_call),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_byte       (out_ch.out_byte)
);
